// ----- sv/arpc_pkg.sv -----
package arpc_pkg;

	// Sizing
	localparam int IF_COUNT      = 4;
	localparam int CACHE_ENTRIES = 32;
	localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int IF_SLOTS      = 4;
	localparam int IP_W          = 32;
	localparam int MAC_W         = 48;
	localparam int IFC_W         = 2;
	localparam int KEY_W         = IFC_W + IP_W;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 48;

	localparam logic [IFC_W:0] IF_COUNT_V = (IFC_W + 1)'(IF_COUNT);

	// Item kinds
	localparam logic [1:0] FUNC_RX     = 2'd0;
	localparam logic [1:0] FUNC_REQ    = 2'd1;
	localparam logic [1:0] FUNC_LOOKUP = 2'd2;

	// Result status codes
	localparam logic [2:0] STAT_REPLY    = 3'd0;
	localparam logic [2:0] STAT_DROP     = 3'd1;
	localparam logic [2:0] STAT_REQ_SENT = 3'd2;
	localparam logic [2:0] STAT_HIT      = 3'd3;
	localparam logic [2:0] STAT_MISS     = 3'd4;

	// Emitted operation codes
	localparam logic [1:0] OUT_OP_NONE    = 2'd0;
	localparam logic [1:0] OUT_OP_REQUEST = 2'd1;
	localparam logic [1:0] OUT_OP_REPLY   = 2'd2;

	// Packet field values
	localparam logic [15:0] HW_ETHERNET = 16'h0001;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [15:0] ARP_OP_REQ  = 16'h0001;
	localparam logic [MAC_W-1:0] BCAST_MAC = {(MAC_W / 8){8'hff}};

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC0 = 3'd4;

	typedef struct packed {
		logic [1:0]       func;
		logic [IFC_W-1:0] iface;
		logic [15:0]      hw_type;
		logic [15:0]      proto_type;
		logic [15:0]      arp_opcode;
		logic [MAC_W-1:0] sender_mac;
		logic [IP_W-1:0]  sender_ip;
		logic [IP_W-1:0]  target_ip;
	} in_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [IFC_W-1:0] out_iface;
		logic [1:0]       out_opcode;
		logic [MAC_W-1:0] eth_dst_mac;
		logic [MAC_W-1:0] eth_src_mac;
		logic [IP_W-1:0]  out_sender_ip;
		logic [IP_W-1:0]  out_target_ip;
		logic [MAC_W-1:0] found_mac;
		logic             learn_overflow;
	} out_t;

	// Own interface addresses
	typedef struct packed {
		logic [IF_SLOTS-1:0][IP_W-1:0]  ip;
		logic [IF_SLOTS-1:0][MAC_W-1:0] mac;
	} own_t;

	// One cache entry in memory
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [MAC_W-1:0] mac;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/arpc_ram.sv -----
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/arpc_cfg.sv -----
module arpc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [arpc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [arpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output arpc_pkg::own_t                     own
);
	import arpc_pkg::*;

	own_t own_q;

	// Decode the register index and store the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx < REG_OWN_MAC0) begin
				own_q.ip[cfg_idx[1:0] - REG_OWN_IP0[1:0]] <= cfg_wdata[IP_W-1:0];
			end else begin
				own_q.mac[cfg_idx[1:0] - REG_OWN_MAC0[1:0]] <= cfg_wdata[MAC_W-1:0];
			end
		end
	end

	assign own = own_q;

endmodule

// ----- sv/arpc_engine.sv -----
module arpc_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  arpc_pkg::in_t                   item,
	input  arpc_pkg::own_t                  own,
	output logic                            busy,
	output logic                            done,
	output arpc_pkg::out_t                  result,
	output logic                            ram_we,
	output logic [arpc_pkg::IDX_W-1:0]      ram_waddr,
	output arpc_pkg::entry_t                ram_wdata,
	output logic [arpc_pkg::IDX_W-1:0]      ram_raddr,
	input  arpc_pkg::entry_t                ram_rdata
);
	import arpc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_DISPATCH, ST_SCAN, ST_FINISH} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

	state_t               state_q;
	in_t                  item_q;
	logic [KEY_W-1:0]     key_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 issue_q;
	logic                 cmp_vld_s1;
	logic                 cmp_last_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic                 vld_s1;
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [MAC_W-1:0]     hit_mac_q;
	logic                 free_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic                 done_q;
	out_t                 result_q;

	logic                 ifc_ok;
	logic [IP_W-1:0]      own_ip_sel;
	logic [MAC_W-1:0]     own_mac_sel;
	logic                 tip_own;
	logic                 key_match;
	logic                 emit_d;
	logic                 scan_d;
	out_t                 res_d;

	// Select the interface's own addresses
	assign ifc_ok      = {1'b0, item_q.iface} < IF_COUNT_V;
	assign own_ip_sel  = own.ip[item_q.iface];
	assign own_mac_sel = own.mac[item_q.iface];
	assign tip_own     = item_q.target_ip == own_ip_sel;

	// Shared key comparator on the word read back from the cache
	assign key_match = ram_rdata.key == key_q;

	// Cache memory access
	assign ram_raddr       = idx_q;
	assign ram_we          = (state_q == ST_FINISH) && (item_q.func == FUNC_RX) && (hit_q || free_q);
	assign ram_waddr       = hit_q ? hit_idx_q : free_idx_q;
	assign ram_wdata.key   = key_q;
	assign ram_wdata.mac   = item_q.sender_mac;

	// Build the result word and decide whether a scan is needed
	always_comb begin
		res_d  = '0;
		res_d.status = STAT_DROP;
		emit_d = 1'b0;
		scan_d = 1'b0;
		case (state_q)
			ST_DISPATCH: begin
				case (item_q.func)
					FUNC_RX: begin
						if (ifc_ok && item_q.hw_type == HW_ETHERNET &&
								item_q.proto_type == PROTO_IPV4) begin
							scan_d = 1'b1;
						end else begin
							emit_d = 1'b1;
						end
					end
					FUNC_REQ: begin
						emit_d = 1'b1;
						if (ifc_ok) begin
							res_d.status        = STAT_REQ_SENT;
							res_d.out_iface     = item_q.iface;
							res_d.out_opcode    = OUT_OP_REQUEST;
							res_d.eth_dst_mac   = BCAST_MAC;
							res_d.eth_src_mac   = own_mac_sel;
							res_d.out_sender_ip = own_ip_sel;
							res_d.out_target_ip = item_q.target_ip;
						end
					end
					FUNC_LOOKUP: begin
						if (ifc_ok) begin
							scan_d = 1'b1;
						end else begin
							emit_d = 1'b1;
							res_d.status = STAT_MISS;
						end
					end
					default: begin
						emit_d = 1'b1;
					end
				endcase
			end
			ST_FINISH: begin
				emit_d = 1'b1;
				if (item_q.func == FUNC_RX) begin
					res_d.learn_overflow = !hit_q && !free_q;
					if (item_q.arp_opcode == ARP_OP_REQ && tip_own) begin
						res_d.status        = STAT_REPLY;
						res_d.out_iface     = item_q.iface;
						res_d.out_opcode    = OUT_OP_REPLY;
						res_d.eth_dst_mac   = item_q.sender_mac;
						res_d.eth_src_mac   = own_mac_sel;
						res_d.out_sender_ip = own_ip_sel;
						res_d.out_target_ip = item_q.sender_ip;
					end
				end else if (hit_q) begin
					res_d.status    = STAT_HIT;
					res_d.found_mac = hit_mac_q;
				end else if (tip_own) begin
					res_d.status    = STAT_HIT;
					res_d.found_mac = own_mac_sel;
				end else begin
					res_d.status = STAT_MISS;
				end
			end
			default: begin
				emit_d = 1'b0;
			end
		endcase
	end

	// Sequencer: take an item, sweep the cache when needed, finish and emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			key_q       <= '0;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
			cmp_idx_s1  <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_mac_q   <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			valid_q     <= '0;
			done_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			done_q <= emit_d;
			if (emit_d) begin
				result_q <= res_d;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_q  <= item;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (scan_d) begin
						key_q      <= {item_q.iface, (item_q.func == FUNC_RX) ?
							item_q.sender_ip : item_q.target_ip};
						idx_q      <= '0;
						issue_q    <= 1'b1;
						cmp_vld_s1 <= 1'b0;
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
						state_q    <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					// Issue one read per cycle
					cmp_vld_s1 <= issue_q;
					if (issue_q) begin
						cmp_idx_s1  <= idx_q;
						cmp_last_s1 <= idx_q == LAST_IDX;
						vld_s1      <= valid_q[idx_q];
						if (idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					// Compare the word read back; keep first hit and first free slot
					if (cmp_vld_s1) begin
						if (vld_s1 && key_match && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= cmp_idx_s1;
							hit_mac_q <= ram_rdata.mac;
						end
						if (!vld_s1 && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= cmp_idx_s1;
						end
						if (cmp_last_s1) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (item_q.func == FUNC_RX && !hit_q && free_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

	// A word only comes out of dispatch or finish
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_DISPATCH || $past(state_q) == ST_FINISH))
		else $error("result word without dispatch or finish");

	// Overflow only when every slot is taken
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.learn_overflow) |-> (&valid_q))
		else $error("overflow flagged with a free slot");

	// The last compare ends the sweep
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cmp_vld_s1 && cmp_last_s1) |=> (state_q == ST_FINISH))
		else $error("sweep did not finish after last compare");

	// A hit always points at a valid slot
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && hit_q) |-> valid_q[hit_idx_q])
		else $error("hit on an empty slot");

endmodule

// ----- sv/arp_cache_and_responder_top.sv -----
// A received packet or lookup that passes the checks sweeps the whole cache before its
// result word comes out; a build request or a dropped item gives it straight from dispatch.
// The engine takes no new item until it is idle again (busy low). A sweep is paced by the
// single cache read port and key comparator stepping one slot a cycle.
// The result word is on the ports for one cycle with done high; the receiver cannot stall.
// Reset (arst_n low) clears the cache valid bits, own addresses and the sequencer at once.
module arp_cache_and_responder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  arpc_pkg::in_t                   item,
	output logic                            busy,
	output logic                            done,
	output arpc_pkg::out_t                  result,
	input  logic                            cfg_we,
	input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import arpc_pkg::*;

	own_t             own;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;
	logic [ENTRY_W-1:0] ram_rdata_raw;

	// Own interface addresses
	arpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.own       (own)
	);

	// Cache key and MAC store
	arpc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CACHE_ENTRIES)
	) u_cache (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	// Sequencer with the shared key comparator
	arpc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.own       (own),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

endmodule
